// ----- rtl/commb_register_classifier_defines.svh -----
// assertion macros used by the checker file
`ifndef COMMB_REGISTER_CLASSIFIER_DEFINES_SVH
`define COMMB_REGISTER_CLASSIFIER_DEFINES_SVH

// clocked assertion that is off while reset is low
`define CBRC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked assertion that also holds while reset is low
`define CBRC_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/cbrc_pkg.sv -----
// shared types, format codes and the roll tangent table of the comm-b classifier
package cbrc_pkg;

	typedef enum logic [3:0] {
		FMT_UNKNOWN = 4'd0,
		FMT_AMBIG   = 4'd1,
		FMT_EMPTY   = 4'd2,
		FMT_BDS10   = 4'd3,
		FMT_BDS17   = 4'd4,
		FMT_BDS20   = 4'd5,
		FMT_BDS30   = 4'd6,
		FMT_BDS40   = 4'd7,
		FMT_BDS50   = 4'd8,
		FMT_BDS60   = 4'd9,
		FMT_BDS44   = 4'd10
	} format_t;

	localparam int NUM_SCORERS = 9;

	typedef logic signed [6:0] score_t;

	// scorer slot to format map; a tie for the best score gives FMT_AMBIG whatever the order
	typedef format_t slot_fmt_t [NUM_SCORERS];
	localparam slot_fmt_t SLOT_FMT = '{FMT_EMPTY, FMT_BDS10, FMT_BDS20, FMT_BDS30,
		FMT_BDS17, FMT_BDS40, FMT_BDS50, FMT_BDS60, FMT_BDS44};

	localparam int TAN_W = 17;
	localparam int TAN_DEPTH = 256;
	localparam longint unsigned PI_Q30 = 64'd3373259426;
	localparam int TURN_K_Q8 = 279603;

	typedef logic [TAN_W-1:0] tan_tab_t [TAN_DEPTH];

	// floor quotient by shift and subtract, elaboration only
	function automatic longint unsigned udiv64(input longint unsigned n,
			input longint unsigned d);
		longint unsigned q, r;
		q = '0;
		r = '0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[62:0], n[i]};
			if (r >= d) begin
				r = r - d;
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// q16 tangent of m*pi/1024, q30 taylor series, evaluated at elaboration only
	function automatic tan_tab_t build_tan();
		tan_tab_t t;
		longint unsigned x, x2, term, res;
		longint sn, cs;
		for (int m = 0; m < TAN_DEPTH; m++) begin
			x = (longint'(m) * PI_Q30) >> 10;
			x2 = (x * x) >> 30;
			term = x;
			sn = longint'(x);
			cs = longint'(64'd1 << 30);
			for (int k = 1; k <= 5; k++) begin
				term = udiv64((term * x2) >> 30, 64'((2 * k) * (2 * k + 1)));
				sn = (k % 2 == 1) ? sn - longint'(term) : sn + longint'(term);
			end
			term = 64'd1 << 30;
			for (int k = 1; k <= 6; k++) begin
				term = udiv64((term * x2) >> 30, 64'((2 * k - 1) * (2 * k)));
				cs = (k % 2 == 1) ? cs - longint'(term) : cs + longint'(term);
			end
			if (sn < 0) sn = 0;
			if (cs <= 0) cs = 1;
			res = udiv64(($unsigned(sn) << 16) + ($unsigned(cs) >> 1), $unsigned(cs));
			t[m] = res[TAN_W-1:0];
		end
		return t;
	endfunction

	localparam tan_tab_t TAN_TABLE = build_tan();

endpackage

// ----- rtl/commb_register_classifier.sv -----
// comm-b register classifier: scores one mb field against nine layouts (empty and eight bds)
//
//   channel  signals                                                  dir
//   in       in_valid, in_ready, payload, downlink_request,
//            utility_message, corrected_bits                          sink
//   out      out_valid, out_ready, format, best_score,
//            callsign_text, callsign_ok                               source
//
// four register stages: scorers and tangent lookup, turn multiply,
// turn compare, winner select into the output register.
// one request per cycle while the pipe advances; out_valid rises once it reaches stage four.
// all stages advance together; a held result stalls the whole pipe, nothing lost.
// arst_n clears the valid bits only.
module commb_register_classifier (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [55:0] payload,
	input  logic [4:0]  downlink_request,
	input  logic [5:0]  utility_message,
	input  logic [1:0]  corrected_bits,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  format,
	output logic [5:0]  best_score,
	output logic [63:0] callsign_text,
	output logic        callsign_ok
);

	localparam int SL_EMPTY = 0;
	localparam int SL_10    = 1;
	localparam int SL_20    = 2;
	localparam int SL_30    = 3;
	localparam int SL_17    = 4;
	localparam int SL_40    = 5;
	localparam int SL_50    = 6;
	localparam int SL_60    = 7;
	localparam int SL_44    = 8;
	localparam int TW       = cbrc_pkg::TAN_W;

	logic adv;
	logic v_s1, v_s2, v_s3, v_s4;

	// stage one combinational results
	cbrc_pkg::score_t sc_a [cbrc_pkg::NUM_SCORERS];
	logic [63:0]       text_a;
	logic              skip_a;
	logic              chk_a;
	logic              neg_a;
	logic [TW-1:0]     mag_a;
	logic signed [21:0] ttp_a;
	logic [10:0]       tas_a;

	cbrc_pkg::score_t   sc_s1 [cbrc_pkg::NUM_SCORERS];
	logic [63:0]        text_s1;
	logic               skip_s1, chk_s1, neg_s1;
	logic [TW-1:0]      mag_s1;
	logic signed [21:0] ttp_s1;
	logic [10:0]        tas_s1;

	cbrc_pkg::score_t   sc_s2 [cbrc_pkg::NUM_SCORERS];
	logic [63:0]        text_s2;
	logic               skip_s2, chk_s2, neg_s2;
	logic [35:0]        kmul_s2;
	logic signed [21:0] ttp_s2;
	logic [10:0]        tas_s2;

	cbrc_pkg::score_t   sc_s3 [cbrc_pkg::NUM_SCORERS];
	logic [63:0]        text_s3;
	logic               skip_s3;

	cbrc_pkg::format_t  fmt_s4;
	logic [5:0]         score_s4;
	logic [63:0]        text_s4;
	logic               cs_valid_s4;

	assign adv = !v_s4 || out_ready;
	assign in_ready = adv;

	// 16*raw is off a 500 ft step: works on 4*raw mod 125 by reciprocal
	function automatic logic off500(input logic [11:0] raw);
		logic [13:0] n;
		logic [27:0] prod;
		logic [6:0]  q;
		logic [13:0] r;
		n = {raw, 2'b00};
		prod = 28'(n) * 28'd8389;
		q = prod[26:20];
		r = n - 14'(q * 14'd125);
		return (r >= 14'd4) && (r <= 14'd121);
	endfunction

	// 6-bit character is printable in a callsign
	function automatic logic cs_ok(input logic [5:0] c);
		return c[5] ? ((c == 6'd32) || (c >= 6'd45 && c <= 6'd57))
			: (c >= 6'd1 && c <= 6'd26) || (c == 6'd0);
	endfunction

	// stage one: all scorers, bds 5,0 turn operands
	always_comb begin
		logic [55:0] mb;
		cbrc_pkg::score_t s;
		logic rej;
		logic [15:0] a16;
		logic signed [9:0] roll, trv_s;
		logic signed [14:0] br, nr;
		logic signed [15:0] rd;
		logic signed [10:0] gd;
		logic [9:0] roll_abs;
		logic [7:0] ch;
		mb = payload;
		skip_a = (downlink_request != '0) || (utility_message != '0) || (corrected_bits != '0);

		sc_a[SL_EMPTY] = (mb == '0) ? 7'sd56 : 7'sd0;
		sc_a[SL_10] = (mb[55:48] == 8'h10 && mb[46:42] == '0) ? 7'sd56 : 7'sd0;
		sc_a[SL_30] = (mb[55:48] == 8'h30) ? 7'sd56 : 7'sd0;

		// identification
		rej = (mb[55:48] != 8'h20);
		text_a = '0;
		for (int i = 0; i < 8; i++) begin
			if (!cs_ok(mb[47-6*i -: 6])) rej = 1'b1;
			ch = mb[47-6*i] ? {2'b00, mb[47-6*i -: 6]} : {2'b01, mb[47-6*i -: 6]};
			text_a[63-8*i -: 8] = ch;
		end
		sc_a[SL_20] = rej ? 7'sd0 : 7'sd56;

		// capability report
		s = mb[49] ? 7'sd1 : -7'sd2;
		s = s - (mb[46] ? 7'sd2 : 7'sd0) - (mb[45] ? 7'sd2 : 7'sd0)
			- (mb[44] ? 7'sd2 : 7'sd0) - (mb[43] ? 7'sd2 : 7'sd0)
			- (mb[42] ? 7'sd2 : 7'sd0) - (mb[36] ? 7'sd2 : 7'sd0)
			- (mb[35] ? 7'sd2 : 7'sd0) - (mb[34] ? 7'sd2 : 7'sd0);
		if (mb[55:51] == 5'd31) s = s + (mb[50] ? 7'sd6 : 7'sd5);
		else if (mb[55:50] == '0) s = s + 7'sd1;
		else s = s - 7'sd12;
		if (mb[40] && mb[32]) s = s + (mb[47] ? 7'sd3 : 7'sd2);
		else if (!mb[40] && !mb[32] && !mb[47]) s = s + 7'sd1;
		else s = s - 7'sd6;
		sc_a[SL_17] = (mb[31:0] != '0) ? 7'sd0 : s;

		// selected vertical intention
		rej = !(mb[55] || mb[42] || mb[29] || mb[8] || mb[2]);
		s = '0;
		a16 = {mb[54:43], 4'b0000};
		if (mb[55] && mb[54:43] != '0) begin
			if (a16 >= 16'd1000 && a16 <= 16'd50000) s = s + 7'sd13;
			else rej = 1'b1;
		end else if (!mb[55] && mb[54:43] == '0) s = s + 7'sd1;
		else rej = 1'b1;
		a16 = {mb[41:30], 4'b0000};
		if (mb[42] && mb[41:30] != '0) begin
			if (a16 >= 16'd1000 && a16 <= 16'd50000) s = s + 7'sd13;
			else rej = 1'b1;
		end else if (!mb[42] && mb[41:30] == '0) s = s + 7'sd1;
		else rej = 1'b1;
		if (mb[29] && mb[28:17] != '0) begin
			if (mb[28:17] >= 12'd1000 && mb[28:17] <= 12'd3000) s = s + 7'sd13;
			else rej = 1'b1;
		end else if (!mb[29] && mb[28:17] == '0) s = s + 7'sd1;
		else rej = 1'b1;
		if (mb[16:9] != '0) rej = 1'b1;
		if (mb[8]) s = s + 7'sd4;
		else if (mb[7:5] == '0) s = s + 7'sd1;
		else rej = 1'b1;
		if (mb[4:3] != '0) rej = 1'b1;
		if (mb[2]) s = s + 7'sd3;
		else if (mb[1:0] == '0) s = s + 7'sd1;
		else rej = 1'b1;
		if (mb[55] && mb[42] && mb[54:43] != mb[41:30]) s = s - 7'sd4;
		if (mb[55] && off500(mb[54:43])) s = s - 7'sd4;
		if (mb[42] && off500(mb[41:30])) s = s - 7'sd4;
		sc_a[SL_40] = rej ? 7'sd0 : s;

		// track and turn report, turn consistency finished in stage three
		roll = {mb[54], mb[53:45]};
		rej = !(mb[55] && mb[44] && mb[32] && mb[10]);
		if (roll < -10'sd227 || roll > 10'sd227) rej = 1'b1;
		if (mb[31:22] < 10'd25 || mb[31:22] > 10'd350) rej = 1'b1;
		if (mb[9:0] < 10'd25 || mb[9:0] > 10'd350) rej = 1'b1;
		s = 7'sd45;
		trv_s = '0;
		if (mb[21]) begin
			trv_s = {mb[20], mb[19:11]};
			if (trv_s < -10'sd320 || trv_s > 10'sd320) rej = 1'b1;
			s = s + 7'sd11;
		end else if (mb[19:11] == '0 && !mb[20]) s = s + 7'sd1;
		else rej = 1'b1;
		gd = $signed({1'b0, mb[31:22]}) - $signed({1'b0, mb[9:0]});
		if (gd > 11'sd75 || gd < -11'sd75) s = s - 7'sd6;
		sc_a[SL_50] = rej ? 7'sd0 : s;
		chk_a = !rej && mb[21];
		neg_a = roll[9];
		roll_abs = roll[9] ? 10'(-roll) : 10'(roll);
		mag_a = cbrc_pkg::TAN_TABLE[roll_abs[7:0]];
		tas_a = {mb[9:0], 1'b0};
		ttp_a = trv_s * $signed({1'b0, tas_a});

		// heading and speed report
		rej = !(mb[55] && mb[43] && mb[32] && (mb[21] || mb[10]));
		if (mb[42:33] < 10'd50 || mb[42:33] > 10'd700) rej = 1'b1;
		if (mb[31:22] < 10'd25 || mb[31:22] > 10'd225) rej = 1'b1;
		s = 7'sd34;
		br = '0;
		nr = '0;
		if (mb[21]) begin
			br = $signed({mb[20], mb[19:11], 5'b00000});
			if (br < -15'sd6000 || br > 15'sd6000) rej = 1'b1;
			s = s + 7'sd11;
		end else if (mb[19:11] == '0) s = s + 7'sd1;
		else rej = 1'b1;
		if (mb[10]) begin
			nr = $signed({mb[9], mb[8:0], 5'b00000});
			if (nr < -15'sd6000 || nr > 15'sd6000) rej = 1'b1;
			s = s + 7'sd11;
		end else if (mb[8:0] == '0) s = s + 7'sd1;
		else rej = 1'b1;
		rd = 16'(br) - 16'(nr);
		if (mb[21] && mb[10] && (rd > 16'sd2000 || rd < -16'sd2000)) s = s - 7'sd12;
		sc_a[SL_60] = rej ? 7'sd0 : s;

		// meteorological routine report
		rej = (mb[55:52] > 4'd6);
		if (mb[32] ? (mb[31:22] < 10'd512) : (mb[31:22] > 10'd512)) rej = 1'b1;
		s = 7'sd14 + (mb[51] ? 7'sd18 : 7'sd2) + (mb[21] ? 7'sd11 : 7'sd1)
			+ (mb[9] ? 7'sd2 : 7'sd1) + (mb[6] ? 7'sd6 : 7'sd1);
		sc_a[SL_44] = rej ? 7'sd0 : s;
	end

	// stage three: turn rate against bank angle
	cbrc_pkg::score_t sc_c [cbrc_pkg::NUM_SCORERS];
	always_comb begin
		logic signed [39:0] kt, tt, diff, lim;
		kt = neg_s2 ? -$signed({4'b0000, kmul_s2}) : $signed({4'b0000, kmul_s2});
		tt = 40'(ttp_s2) <<< 19;
		diff = kt - tt;
		if (diff < 0) diff = -diff;
		lim = $signed({4'b0000, tas_s2, 25'b0});
		sc_c = sc_s2;
		if (chk_s2 && diff > lim) sc_c[SL_50] = sc_s2[SL_50] - 7'sd6;
	end

	// stage four: running best in scorer order
	cbrc_pkg::format_t fmt_d;
	logic [5:0]        score_d;
	logic [63:0]       text_d;
	logic              cs_valid_d;
	always_comb begin
		cbrc_pkg::score_t best;
		logic [3:0] win;
		logic have, amb;
		best = '0;
		win = '0;
		have = 1'b0;
		amb = 1'b0;
		for (int i = 0; i < cbrc_pkg::NUM_SCORERS; i++) begin
			if (sc_s3[i] > best) begin
				best = sc_s3[i];
				win = 4'(i);
				have = 1'b1;
				amb = 1'b0;
			end else if (sc_s3[i] == best) begin
				amb = 1'b1;
			end
		end
		fmt_d = cbrc_pkg::FMT_UNKNOWN;
		score_d = '0;
		text_d = '0;
		cs_valid_d = 1'b0;
		if (!skip_s3 && have) begin
			score_d = best[5:0];
			if (amb) begin
				fmt_d = cbrc_pkg::FMT_AMBIG;
			end else begin
				fmt_d = cbrc_pkg::SLOT_FMT[win];
				if (win == 4'(SL_20)) begin
					text_d = text_s3;
					cs_valid_d = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sc_s1 <= sc_a;
			text_s1 <= text_a;
			skip_s1 <= skip_a;
			chk_s1 <= chk_a;
			neg_s1 <= neg_a;
			mag_s1 <= mag_a;
			ttp_s1 <= ttp_a;
			tas_s1 <= tas_a;

			sc_s2 <= sc_s1;
			text_s2 <= text_s1;
			skip_s2 <= skip_s1;
			chk_s2 <= chk_s1;
			neg_s2 <= neg_s1;
			kmul_s2 <= 36'(mag_s1) * 36'(cbrc_pkg::TURN_K_Q8);
			ttp_s2 <= ttp_s1;
			tas_s2 <= tas_s1;

			sc_s3 <= sc_c;
			text_s3 <= text_s2;
			skip_s3 <= skip_s2;

			fmt_s4 <= fmt_d;
			score_s4 <= score_d;
			text_s4 <= text_d;
			cs_valid_s4 <= cs_valid_d;
		end
	end

	assign out_valid = v_s4;
	assign format = fmt_s4;
	assign best_score = score_s4;
	assign callsign_text = text_s4;
	assign callsign_ok = cs_valid_s4;

endmodule

// ----- rtl/cbrc_checker.sv -----
// port checker for the comm-b classifier and its bind
`include "commb_register_classifier_defines.svh"

module cbrc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [3:0]  format,
	input logic [5:0]  best_score,
	input logic [63:0] callsign_text,
	input logic        callsign_ok
);

	`CBRC_ASSERT_ALWAYS(a_rst_empty, !arst_n |-> !out_valid, "out_valid during reset")

	`CBRC_ASSERT(a_hold, out_valid && !out_ready |=> out_valid && $stable(format)
		&& $stable(best_score) && $stable(callsign_text), "held result changed")

	`CBRC_ASSERT(a_cs_fmt, out_valid && callsign_ok |-> format == cbrc_pkg::FMT_BDS20,
		"callsign flag off identification")

	`CBRC_ASSERT(a_cs_zero, out_valid && format != cbrc_pkg::FMT_BDS20
		|-> callsign_text == '0 && !callsign_ok, "callsign text outside identification")

	`CBRC_ASSERT(a_unknown, out_valid && format == cbrc_pkg::FMT_UNKNOWN
		|-> best_score == '0, "score on unknown format")

endmodule

bind commb_register_classifier cbrc_checker u_cbrc_checker (.*);

// ----- dv/tb_top.sv -----
// self-checking testbench for the comm-b register classifier
`timescale 1ns / 100ps

module tb_top;

	localparam longint unsigned PI_Q30_TB = 64'd3373259426;
	localparam longint TURN_GAIN = 279603;

	typedef struct {
		cbrc_pkg::format_t fmt;
		logic [5:0]  score;
		logic [63:0] text;
		logic        text_ok;
	} verdict_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [55:0] payload;
	logic [4:0]  downlink_request;
	logic [5:0]  utility_message;
	logic [1:0]  corrected_bits;
	logic        out_valid;
	logic        out_ready;
	logic [3:0]  format;
	logic [5:0]  best_score;
	logic [63:0] callsign_text;
	logic        callsign_ok;

	verdict_t verdict_q[$];
	int       errors = 0;
	int       checked = 0;
	int       fmt_seen[11];
	int       idle_pct = 0;
	int       stall_pct = 0;

	commb_register_classifier i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.payload(payload), .downlink_request(downlink_request),
		.utility_message(utility_message), .corrected_bits(corrected_bits),
		.out_valid(out_valid), .out_ready(out_ready),
		.format(format), .best_score(best_score),
		.callsign_text(callsign_text), .callsign_ok(callsign_ok)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ---------------- predictor ----------------

	// message bits a..b, bit 1 being the msb of the message
	function automatic int unsigned fld(logic [55:0] m, int a, int b);
		longint unsigned v;
		v = (64'(m) >> (56 - b)) & ((64'd1 << (b - a + 1)) - 64'd1);
		return int'(v);
	endfunction

	function automatic logic [55:0] setf(logic [55:0] m, int a, int b, longint unsigned v);
		logic [55:0] mask;
		mask = 56'(((64'd1 << (b - a + 1)) - 64'd1) << (56 - b));
		return (m & ~mask) | (56'(v << (56 - b)) & mask);
	endfunction

	function automatic int altitude_pts(int unsigned v, int unsigned raw);
		if (v && raw != 0)
			return (raw * 16 >= 1000 && raw * 16 <= 50000) ? 13 : -1;
		return (!v && raw == 0) ? 1 : -1;
	endfunction

	function automatic bit far_from_500(int unsigned alt);
		int unsigned r;
		r = alt % 500;
		return !(r < 16 || r > 484);
	endfunction

	// q16 tangent of m*pi/1024 from truncated taylor series in q30
	function automatic longint roll_tangent(int m);
		longint unsigned x, x2, term;
		longint sn, cs;
		x = (longint'(m & 255) * PI_Q30_TB) >> 10;
		x2 = (x * x) >> 30;
		term = x;
		sn = longint'(x);
		cs = longint'(64'd1 << 30);
		for (int k = 1; k <= 5; k++) begin
			term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
			sn = (k % 2) ? sn - longint'(term) : sn + longint'(term);
		end
		term = 64'd1 << 30;
		for (int k = 1; k <= 6; k++) begin
			term = ((term * x2) >> 30) / longint'((2 * k - 1) * (2 * k));
			cs = (k % 2) ? cs - longint'(term) : cs + longint'(term);
		end
		if (sn < 0) sn = 0;
		if (cs <= 0) cs = 1;
		return ((sn <<< 16) + cs / 2) / cs;
	endfunction

	function automatic int ident_score(logic [55:0] m, output logic [63:0] text);
		logic [7:0] ch;
		int unsigned c;
		text = '0;
		if (fld(m, 1, 8) != 'h20) return 0;
		for (int i = 0; i < 8; i++) begin
			c = fld(m, 9 + 6 * i, 14 + 6 * i);
			ch = 8'(c < 32 ? c + 64 : c);
			if (!((ch >= "A" && ch <= "Z") || (ch >= "-" && ch <= "9") || ch == " " || ch == "@"))
				return 0;
			text = {text[55:0], ch};
		end
		return 56;
	endfunction

	function automatic int caps_score(logic [55:0] m);
		int s;
		int unlikely[8] = '{10, 11, 12, 13, 14, 20, 21, 22};
		s = 0;
		if (fld(m, 25, 56) != 0) return 0;
		s += fld(m, 7, 7) ? 1 : -2;
		foreach (unlikely[i]) if (fld(m, unlikely[i], unlikely[i])) s -= 2;
		if (fld(m, 1, 5) == 31) begin
			s += 5;
			if (fld(m, 6, 6)) s += 1;
		end else if (fld(m, 1, 6) == 0) s += 1;
		else s -= 12;
		if (fld(m, 16, 16) && fld(m, 24, 24)) begin
			s += 2;
			if (fld(m, 9, 9)) s += 1;
		end else if (!fld(m, 16, 16) && !fld(m, 24, 24) && !fld(m, 9, 9)) s += 1;
		else s -= 6;
		return s;
	endfunction

	function automatic int intent_score(logic [55:0] m);
		int unsigned mv, mr, fv, fr, bv, br, modev, moder, sv, sr;
		int s, p;
		mv = fld(m, 1, 1); mr = fld(m, 2, 13); fv = fld(m, 14, 14); fr = fld(m, 15, 26);
		bv = fld(m, 27, 27); br = fld(m, 28, 39);
		modev = fld(m, 48, 48); moder = fld(m, 49, 51); sv = fld(m, 54, 54); sr = fld(m, 55, 56);
		s = 0;
		if (!mv && !fv && !bv && !modev && !sv) return 0;
		p = altitude_pts(mv, mr);
		if (p < 0) return 0;
		s += p;
		p = altitude_pts(fv, fr);
		if (p < 0) return 0;
		s += p;
		if (bv && br != 0) begin
			if (br < 1000 || br > 3000) return 0;
			s += 13;
		end else if (!bv && br == 0) s += 1;
		else return 0;
		if (fld(m, 40, 47) != 0) return 0;
		if (modev) s += 4;
		else if (moder == 0) s += 1;
		else return 0;
		if (fld(m, 52, 53) != 0) return 0;
		if (sv) s += 3;
		else if (sr == 0) s += 1;
		else return 0;
		if (mv && fv && mr != fr) s -= 4;
		if (mv && far_from_500(mr * 16)) s -= 4;
		if (fv && far_from_500(fr * 16)) s -= 4;
		return s;
	endfunction

	function automatic int speed_pts(int unsigned v, int unsigned raw, output int kt);
		kt = int'(raw) * 2;
		if (v && raw != 0) return (kt >= 50 && kt <= 700) ? 11 : -1;
		return (!v && raw == 0) ? 1 : -1;
	endfunction

	function automatic int track_score(logic [55:0] m);
		int roll, tr, gs, tas, p, d, s;
		int unsigned trraw, trsign, trv;
		longint t, diff;
		trv = fld(m, 35, 35);
		roll = int'(fld(m, 3, 11)) - (fld(m, 2, 2) ? 512 : 0);
		trraw = fld(m, 37, 45);
		trsign = fld(m, 36, 36);
		tr = 0;
		s = 0;
		if (!fld(m, 1, 1) || !fld(m, 12, 12) || !fld(m, 24, 24) || !fld(m, 46, 46)) return 0;
		if (roll * 45 < -10240 || roll * 45 >= 10240) return 0;
		s += 23;
		p = speed_pts(1, fld(m, 25, 34), gs);
		if (p < 0) return 0;
		s += p;
		if (trv) begin
			tr = int'(trraw) - (trsign ? 512 : 0);
			if (tr < -320 || tr > 320) return 0;
			s += 11;
		end else if (trraw == 0 && !trsign) s += 1;
		else return 0;
		p = speed_pts(1, fld(m, 47, 56), tas);
		if (p < 0) return 0;
		s += p;
		d = gs - tas;
		if (d > 150 || d < -150) s -= 6;
		if (trv && tas > 0) begin
			t = roll < 0 ? -roll_tangent(-roll) : roll_tangent(roll);
			diff = TURN_GAIN * t - longint'(tr) * tas * 524288;
			if (diff < 0) diff = -diff;
			if (diff > longint'(tas) * 33554432) s -= 6;
		end
		return s;
	endfunction

	function automatic int vrate_pts(int unsigned v, int unsigned sgn, int unsigned raw,
			output int rate);
		rate = 0;
		if (v) begin
			rate = int'(raw) * 32 - (sgn ? 16384 : 0);
			return (rate >= -6000 && rate <= 6000) ? 11 : -1;
		end
		return raw == 0 ? 1 : -1;
	endfunction

	function automatic int heading_score(logic [55:0] m);
		int unsigned bv, nv, ias, mach;
		int s, p, br, nr, d;
		bv = fld(m, 35, 35); nv = fld(m, 46, 46);
		ias = fld(m, 14, 23); mach = fld(m, 25, 34);
		s = 12;
		if (!fld(m, 1, 1) || !fld(m, 13, 13) || !fld(m, 24, 24) || (!bv && !nv)) return 0;
		if (ias < 50 || ias > 700) return 0;
		s += 11;
		if (mach < 25 || mach > 225) return 0;
		s += 11;
		p = vrate_pts(bv, fld(m, 36, 36), fld(m, 37, 45), br);
		if (p < 0) return 0;
		s += p;
		p = vrate_pts(nv, fld(m, 47, 47), fld(m, 48, 56), nr);
		if (p < 0) return 0;
		s += p;
		d = br - nr;
		if (bv && nv && (d > 2000 || d < -2000)) s -= 12;
		return s;
	endfunction

	function automatic int meteo_score(logic [55:0] m);
		int s;
		int unsigned temp;
		s = 4;
		temp = fld(m, 25, 34);
		if (fld(m, 1, 4) > 6) return 0;
		s += fld(m, 5, 5) ? 18 : 2;
		if (fld(m, 24, 24) ? (temp < 512) : (temp > 512)) return 0;
		s += 10;
		s += fld(m, 35, 35) ? 11 : 1;
		s += fld(m, 47, 47) ? 2 : 1;
		s += fld(m, 50, 50) ? 6 : 1;
		return s;
	endfunction

	function automatic verdict_t classify(logic [55:0] m, logic [4:0] dr, logic [5:0] um,
			logic [1:0] cb);
		verdict_t v;
		int sc[9];
		int best, win;
		bit have, amb;
		logic [63:0] text;
		cbrc_pkg::format_t slot_fmt[9] = '{cbrc_pkg::FMT_EMPTY, cbrc_pkg::FMT_BDS10,
			cbrc_pkg::FMT_BDS20, cbrc_pkg::FMT_BDS30, cbrc_pkg::FMT_BDS17,
			cbrc_pkg::FMT_BDS40, cbrc_pkg::FMT_BDS50, cbrc_pkg::FMT_BDS60,
			cbrc_pkg::FMT_BDS44};
		v = '{cbrc_pkg::FMT_UNKNOWN, '0, '0, 1'b0};
		best = 0; win = 0; have = 0; amb = 0;
		if (dr != 0 || um != 0 || cb != 0) return v;
		sc[0] = (m == 0) ? 56 : 0;
		sc[1] = (fld(m, 1, 8) == 'h10 && fld(m, 10, 14) == 0) ? 56 : 0;
		sc[2] = ident_score(m, text);
		sc[3] = (fld(m, 1, 8) == 'h30) ? 56 : 0;
		sc[4] = caps_score(m);
		sc[5] = intent_score(m);
		sc[6] = track_score(m);
		sc[7] = heading_score(m);
		sc[8] = meteo_score(m);
		for (int i = 0; i < 9; i++) begin
			if (sc[i] > best) begin
				best = sc[i]; win = i; have = 1; amb = 0;
			end else if (sc[i] == best) amb = 1;
		end
		if (!have) return v;
		v.score = 6'(best);
		if (amb) v.fmt = cbrc_pkg::FMT_AMBIG;
		else begin
			v.fmt = slot_fmt[win];
			if (win == 2) begin
				v.text = text;
				v.text_ok = 1'b1;
			end
		end
		return v;
	endfunction

	// ---------------- monitors ----------------

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			verdict_q.push_back(classify(payload, downlink_request, utility_message,
				corrected_bits));
	end

	always @(posedge clk) begin
		verdict_t e;
		if (arst_n && out_valid && out_ready) begin
			if (verdict_q.size() == 0) begin
				$error("result with no request outstanding: format %0d", format);
				errors++;
			end else begin
				e = verdict_q.pop_front();
				checked++;
				if (format <= 10) fmt_seen[format]++;
				if (format !== e.fmt) begin
					$error("format: expected %0d, actual %0d", e.fmt, format);
					errors++;
				end
				if (best_score !== e.score) begin
					$error("best_score: expected %0d, actual %0d", e.score, best_score);
					errors++;
				end
				if (callsign_text !== e.text) begin
					$error("callsign_text: expected %h, actual %h", e.text, callsign_text);
					errors++;
				end
				if (callsign_ok !== e.text_ok) begin
					$error("callsign_ok: expected %0d, actual %0d", e.text_ok,
						callsign_ok);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// ---------------- stimulus ----------------

	task automatic send_msg(logic [55:0] m, logic [4:0] dr = 0, logic [5:0] um = 0,
			logic [1:0] cb = 0);
		in_valid <= 1'b1;
		payload <= m;
		downlink_request <= dr;
		utility_message <= um;
		corrected_bits <= cb;
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
		if ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
		end
	endtask

	function automatic logic [55:0] make_ident();
		logic [55:0] m;
		int codes[39];
		for (int i = 0; i < 26; i++) codes[i] = i + 1;
		for (int i = 0; i < 13; i++) codes[26 + i] = 45 + i;
		m = setf(56'd0, 1, 8, 'h20);
		for (int i = 0; i < 8; i++)
			m = setf(m, 9 + 6 * i, 14 + 6 * i,
				$urandom_range(0, 9) == 0 ? ($urandom_range(0, 1) ? 32 : 0)
				: codes[$urandom_range(0, 38)]);
		if ($urandom_range(0, 15) == 0) m = setf(m, 9, 14, $urandom_range(27, 31));
		return m;
	endfunction

	function automatic logic [55:0] make_caps();
		logic [55:0] m;
		m = setf(56'd0, 1, 24, $urandom_range(0, 24'hffffff));
		if ($urandom_range(0, 1)) m = setf(m, 1, 5, 31);
		if ($urandom_range(0, 1)) m = setf(m, 10, 14, 0);
		if ($urandom_range(0, 1)) m = setf(m, 20, 22, 0);
		return m;
	endfunction

	function automatic logic [55:0] make_intent();
		logic [55:0] m;
		int unsigned mr;
		mr = $urandom_range(0, 3) == 0 ? 500 * $urandom_range(2, 100) / 16 : $urandom_range(63, 3125);
		m = '0;
		if ($urandom_range(0, 3)) m = setf(setf(m, 1, 1, 1), 2, 13, mr);
		if ($urandom_range(0, 3))
			m = setf(setf(m, 14, 14, 1), 15, 26, $urandom_range(0, 1) ? mr : $urandom_range(63, 3125));
		if ($urandom_range(0, 1)) m = setf(setf(m, 27, 27, 1), 28, 39, $urandom_range(1000, 3000));
		m = setf(m, 48, 48, $urandom_range(0, 1));
		if (fld(m, 48, 48)) m = setf(m, 49, 51, $urandom_range(0, 7));
		m = setf(m, 54, 54, $urandom_range(0, 1));
		if (fld(m, 54, 54)) m = setf(m, 55, 56, $urandom_range(0, 3));
		if ($urandom_range(0, 9) == 0) m = setf(m, 40, 47, $urandom_range(1, 255));
		return m;
	endfunction

	function automatic logic [55:0] make_track();
		logic [55:0] m;
		int roll, tas, tr;
		roll = $urandom_range(0, 454) - 227;
		tas = $urandom_range(25, 350);
		// turn rate near the coordinated-turn value for this roll and speed, or near zero
		tr = ($urandom_range(0, 1) ? 0 : (roll * 2000 / (tas + 1))) + $urandom_range(0, 20) - 10;
		if (tr > 320) tr = 320;
		if (tr < -320) tr = -320;
		m = setf(56'd0, 1, 1, 1);
		m = setf(m, 2, 11, roll & 'h3ff);
		m = setf(m, 12, 12, 1);
		m = setf(m, 13, 23, $urandom_range(0, 2047));
		m = setf(m, 24, 24, 1);
		m = setf(m, 25, 34, $urandom_range(0, 1) ? tas + $urandom_range(0, 100) - 50
			: $urandom_range(25, 350));
		if ($urandom_range(0, 3)) m = setf(setf(m, 35, 35, 1), 36, 45, tr & 'h3ff);
		m = setf(m, 46, 46, 1);
		m = setf(m, 47, 56, tas);
		if ($urandom_range(0, 15) == 0) m = setf(m, 25, 34, $urandom_range(0, 1023));
		return m;
	endfunction

	function automatic logic [55:0] make_vrate(logic [55:0] m, int a);
		int raw;
		raw = $urandom_range(0, 1) ? $urandom_range(0, 187) : $urandom_range(325, 511);
		if ($urandom_range(0, 4) == 0) return setf(m, a, a + 10, 0);
		return setf(setf(m, a, a, 1), a + 1, a + 10, (raw >= 325 ? 512 : 0) + raw);
	endfunction

	function automatic logic [55:0] make_heading();
		logic [55:0] m;
		m = setf(56'd0, 1, 12, $urandom_range(0, 4095) | 'h800);
		m = setf(m, 13, 13, 1);
		m = setf(m, 14, 23, $urandom_range(0, 7) == 0 ? $urandom_range(0, 1023) : $urandom_range(50, 700));
		m = setf(m, 24, 24, 1);
		m = setf(m, 25, 34, $urandom_range(0, 7) == 0 ? $urandom_range(0, 1023) : $urandom_range(25, 225));
		m = make_vrate(m, 35);
		m = make_vrate(m, 46);
		return m;
	endfunction

	function automatic logic [55:0] make_meteo();
		logic [55:0] m;
		m = {$urandom(), $urandom()};
		m = setf(m, 1, 4, $urandom_range(0, 7) == 0 ? $urandom_range(7, 15) : $urandom_range(0, 6));
		m = setf(m, 24, 24, $urandom_range(0, 1));
		m = setf(m, 25, 34, fld(m, 24, 24) ? $urandom_range(512, 1023) : $urandom_range(0, 512));
		return m;
	endfunction

	function automatic logic [55:0] make_any();
		case ($urandom_range(0, 9))
			0: return make_ident();
			1: return make_caps();
			2: return make_intent();
			3: return make_track();
			4: return make_heading();
			5: return make_meteo();
			6: return setf({$urandom(), $urandom()}, 1, 8, $urandom_range(0, 1) ? 'h10 : 'h30);
			7: return $urandom_range(0, 3) ? {$urandom(), $urandom()} : 56'd0;
			default: return $urandom_range(0, 1) ? make_track() : make_heading();
		endcase
	endfunction

	task automatic test_skip_flags();
		send_msg(56'd0, 5'd1);
		send_msg(56'hff_ffff_ffff_ffff, 5'd31, 6'd63, 2'd3);
		send_msg(setf(56'd0, 1, 8, 'h30), 5'd0, 6'd32);
		send_msg(setf(56'd0, 1, 8, 'h10), 5'd0, 6'd0, 2'd1);
	endtask

	task automatic test_fixed_layouts();
		send_msg(56'd0);
		send_msg(56'hff_ffff_ffff_ffff);
		send_msg(setf(56'd0, 1, 8, 'h10));
		send_msg(setf(setf(56'd0, 1, 8, 'h10), 10, 14, 1));
		send_msg(setf(56'd0, 1, 8, 'h30) | 56'h00_ffff_ffff_ffff);
		send_msg(56'h20_0000_0000_0000);
		send_msg(make_ident());
		send_msg(setf(make_ident(), 9, 14, 63));
	endtask

	task automatic test_scored_layouts();
		send_msg(setf(setf(56'd0, 1, 7, 7'h7f), 16, 16, 1) | 56'h00_0081_0000_0000);
		send_msg(make_caps());
		send_msg(make_intent());
		send_msg(make_intent());
		send_msg(make_track());
		send_msg(make_track());
		send_msg(make_heading());
		send_msg(make_heading());
		send_msg(make_meteo());
		send_msg(make_meteo());
	endtask

	task automatic test_random_mix();
		int idle_set[4] = '{0, 45, 0, 15};
		int stall_set[4] = '{0, 0, 45, 15};
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = idle_set[ph];
			stall_pct = stall_set[ph];
			for (int n = 0; n < 100; n++) begin
				if ($urandom_range(0, 9) == 0)
					send_msg(make_any(), $urandom_range(0, 1) ? 5'($urandom()) : 5'd0,
						$urandom_range(0, 1) ? 6'($urandom()) : 6'd0, 2'($urandom()));
				else
					send_msg(make_any());
			end
		end
	endtask

	initial begin
		string tally;
		arst_n = 1'b0;
		in_valid = 1'b0;
		payload = '0;
		downlink_request = '0;
		utility_message = '0;
		corrected_bits = '0;
		out_ready = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_skip_flags();
		test_fixed_layouts();
		test_scored_layouts();
		test_random_mix();
		in_valid <= 1'b0;
		while (verdict_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		tally = "";
		for (int f = 0; f < 11; f++) tally = {tally, $sformatf(" %0d:%0d", f, fmt_seen[f])};
		$display("checked %0d classifications under four idle/stall mixes", checked);
		$display("results per format code:%s", tally);
		if (errors == 0)
			$display("commb_register_classifier: match");
		else
			$display("commb_register_classifier: mismatch");
		$finish;
	end

	initial begin
		#5ms;
		$display("commb_register_classifier: mismatch");
		$finish;
	end

endmodule
